/* hdl/gbte_pkg.sv */
// gbte_pkg: types and codes shared by the gap-buffer text store.
// Holds the beat structs, mode and status codes, and the controller state type.
// No dependencies.
`default_nettype none

package gbte_pkg;

  localparam logic [2:0] MODE_INSERT    = 3'd0;
  localparam logic [2:0] MODE_BACKSPACE = 3'd1;
  localparam logic [2:0] MODE_LEFT      = 3'd2;
  localparam logic [2:0] MODE_RIGHT     = 3'd3;
  localparam logic [2:0] MODE_READ      = 3'd4;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EDGE  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_in;
    logic [9:0] read_index;
  } gbte_in_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [10:0] cursor_pos;
    logic [10:0] text_length;
    logic [1:0]  status;
  } gbte_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } gbte_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } gbte_ctl_t;

endpackage

`default_nettype wire

/* hdl/gbte_ctrl.sv */
// gbte_ctrl: sequencing state machine and output valid for the gap buffer.
// Issues capture and commit commands to gbte_dpath. Uses gbte_pkg.
`default_nettype none

module gbte_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output gbte_pkg::gbte_ctl_t ctl,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall
);
  import gbte_pkg::*;

  gbte_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_free       = !out_valid || !out_stall;
    state_next     = state;
    ctl.capture    = 1'b0;
    ctl.commit     = 1'b0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold the finished item until the result register frees up
        if (out_free) begin
          ctl.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/gbte_dpath.sv */
// gbte_dpath: text memory, cursor counts, address logic and result register.
// Driven by gbte_ctrl commands. Uses gbte_pkg.
`default_nettype none

module gbte_dpath #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gbte_pkg::gbte_ctl_t ctl,
  input  wire gbte_pkg::gbte_in_t  in_data,
  output gbte_pkg::gbte_out_t      out_data
);
  import gbte_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 10) ? CW : 10;
  localparam int EW = (CW > 11) ? CW : 11;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          we;

  logic [CW-1:0] before_count, after_count;
  logic [CW-1:0] before_count_next, after_count_next;
  logic [CW-1:0] total, total_next;

  logic [2:0]    mode_q;
  logic [7:0]    char_q;
  logic [9:0]    idx_q;

  logic [XW-1:0] in_idx_x, before_x, total_x, idx_x;
  logic [CW-1:0] in_idx_c;
  logic [EW-1:0] before_e, total_e;
  logic [1:0]    status_c;
  logic [7:0]    char_c;

  assign total    = before_count + after_count;
  assign in_idx_x = XW'(in_data.read_index);
  assign in_idx_c = CW'(in_idx_x);
  assign before_x = XW'(before_count);
  assign total_x  = XW'(total);
  assign idx_x    = XW'(idx_q);

  // Read address for the item being captured; counts are stable until commit.
  always_comb begin
    case (in_data.mode)
      MODE_LEFT:  raddr = AW'(before_count - CW'(1));
      MODE_RIGHT: raddr = AW'(CAP_C - after_count);
      default: begin
        if (in_idx_x < before_x) begin
          raddr = AW'(in_idx_c);
        end else begin
          raddr = AW'(CAP_C - after_count + in_idx_c - before_count);
        end
      end
    endcase
  end

  always_comb begin
    status_c          = STAT_DONE;
    char_c            = 8'd0;
    we                = 1'b0;
    waddr             = AW'(before_count);
    wdata             = rd_data;
    before_count_next = before_count;
    after_count_next  = after_count;
    case (mode_q)
      MODE_INSERT: begin
        if (total >= CAP_C) begin
          status_c = STAT_FULL;
        end else begin
          we                = 1'b1;
          wdata             = char_q;
          before_count_next = before_count + CW'(1);
        end
      end
      MODE_BACKSPACE: begin
        if (before_count == '0) begin
          status_c = STAT_EDGE;
        end else begin
          before_count_next = before_count - CW'(1);
        end
      end
      MODE_LEFT: begin
        if (before_count == '0) begin
          status_c = STAT_EDGE;
        end else begin
          // move the char left of the cursor to the bottom of the upper run
          we                = 1'b1;
          waddr             = AW'(CAP_C - after_count - CW'(1));
          before_count_next = before_count - CW'(1);
          after_count_next  = after_count + CW'(1);
        end
      end
      MODE_RIGHT: begin
        if (after_count == '0) begin
          status_c = STAT_EDGE;
        end else begin
          we                = 1'b1;
          before_count_next = before_count + CW'(1);
          after_count_next  = after_count - CW'(1);
        end
      end
      MODE_READ: begin
        if (idx_x >= total_x) begin
          status_c = STAT_RANGE;
        end else begin
          char_c = rd_data;
        end
      end
      default: begin
        status_c = STAT_EDGE;
      end
    endcase
  end

  assign total_next = before_count_next + after_count_next;
  assign before_e   = EW'(before_count_next);
  assign total_e    = EW'(total_next);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      rd_data <= mem[raddr];
    end
    if (ctl.commit && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      before_count <= '0;
      after_count  <= '0;
    end else if (ctl.commit) begin
      before_count <= before_count_next;
      after_count  <= after_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      mode_q <= in_data.mode;
      char_q <= in_data.char_in;
      idx_q  <= in_data.read_index;
    end
    if (ctl.commit) begin
      out_data.char_out    <= char_c;
      out_data.cursor_pos  <= before_e[10:0];
      out_data.text_length <= total_e[10:0];
      out_data.status      <= status_c;
    end
  end

endmodule

`default_nettype wire

/* hdl/gap_buffer_text_editor_top.sv */
// Gap-buffer text store: the memory read happens at the accepting edge, out of ST_IDLE,
// and the write-back, count update and result register load follow in ST_EXEC; out_valid
// rises when the result is loaded, and no new item is taken until the last one has finished.
// A finished result waits in the output register while the next item is accepted;
// a stalled output holds that item in its write cycle and stalls the input.
// Reset clears the cursor counts and the control state; memory is not cleared.
`default_nettype none

module gap_buffer_text_editor_top #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gbte_pkg::gbte_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gbte_pkg::gbte_out_t     out_data
);
  import gbte_pkg::*;

  gbte_ctl_t ctl;

  gbte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .ctl       (ctl),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  gbte_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
